// ===== rtl/escaped_frame_receiver_unit_defines.svh =====
// Assertion macros for the escaped frame receiver unit.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ESCAPED_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`ifndef SYNTHESIS
`define EFR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("efr check failed");
`else
`define EFR_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`endif

// Next-cycle implication, checked on the rising clock edge outside reset.
`ifndef SYNTHESIS
`define EFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("efr check failed");
`else
`define EFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/efr_pkg.sv =====
// Shared types and constants for the escaped frame receiver.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package efr_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 6;
    localparam int M_TDATA_W  = 16;
    localparam int PAD_W      = M_TDATA_W - LEN_W - BYTE_W;
    localparam int CFG_ADDR_W = 2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STOP   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ESCAPE = 2'd2;

    // marker values after reset
    localparam logic [BYTE_W-1:0] START_RESET  = 8'd18;
    localparam logic [BYTE_W-1:0] STOP_RESET   = 8'd19;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;

    // controller to datapath
    typedef struct packed {
        logic clear_fill;
        logic store;
        logic clear_idx;
        logic inc_idx;
        logic rd_en;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_start;
        logic is_stop;
        logic is_escape;
        logic full;
        logic len_zero;
        logic at_last;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/efr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependencies.
`default_nettype none

module efr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/efr_datapath.sv =====
// Datapath: marker registers and compares, frame store, fill count and read index.
// Depends on efr_pkg and efr_ram.
`default_nettype none

module efr_datapath #(
    parameter int FRAME_BYTES = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [efr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [efr_pkg::BYTE_W-1:0]         cfg_wdata,
    input  wire logic [efr_pkg::BYTE_W-1:0]         rx_byte,
    input  wire efr_pkg::cmd_t                      cmd,
    output efr_pkg::sts_t                           sts,
    output logic      [efr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                    m_tlast
);

    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    logic [efr_pkg::BYTE_W-1:0] start_reg,  start_next;
    logic [efr_pkg::BYTE_W-1:0] stop_reg,   stop_next;
    logic [efr_pkg::BYTE_W-1:0] escape_reg, escape_next;
    logic [CW-1:0]              fill_reg,   fill_next;
    logic [CW-1:0]              idx_reg,    idx_next;
    logic [efr_pkg::BYTE_W-1:0] rdata;
    logic [efr_pkg::BYTE_W-1:0] payload;

    always_comb begin
        start_next  = start_reg;
        stop_next   = stop_reg;
        escape_next = escape_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                efr_pkg::CFG_START:  start_next  = cfg_wdata;
                efr_pkg::CFG_STOP:   stop_next   = cfg_wdata;
                efr_pkg::CFG_ESCAPE: escape_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (cmd.clear_fill) begin
            fill_next = '0;
        end else if (cmd.store) begin
            fill_next = fill_reg + CW'(1);
        end
        idx_next = idx_reg;
        if (cmd.clear_idx) begin
            idx_next = '0;
        end else if (cmd.inc_idx) begin
            idx_next = idx_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= efr_pkg::START_RESET;
            stop_reg   <= efr_pkg::STOP_RESET;
            escape_reg <= efr_pkg::ESCAPE_RESET;
            fill_reg   <= '0;
            idx_reg    <= '0;
        end else begin
            start_reg  <= start_next;
            stop_reg   <= stop_next;
            escape_reg <= escape_next;
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
        end
    end

    efr_ram #(
        .WIDTH (efr_pkg::BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.store),
        .waddr (fill_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (cmd.rd_en),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign sts.is_start  = (rx_byte == start_reg);
    assign sts.is_stop   = (rx_byte == stop_reg);
    assign sts.is_escape = (rx_byte == escape_reg);
    assign sts.full      = (fill_reg == CW'(FRAME_BYTES));
    assign sts.len_zero  = (fill_reg == '0);
    assign sts.at_last   = (idx_reg == fill_reg - CW'(1));

    // an empty frame reports a zero byte
    assign payload = sts.len_zero ? '0 : rdata;
    assign m_tdata = {{efr_pkg::PAD_W{1'b0}}, efr_pkg::LEN_W'(fill_reg), payload};
    assign m_tlast = sts.len_zero | sts.at_last;

endmodule

`default_nettype wire

// ===== rtl/efr_ctrl.sv =====
// Controller: receive modes (idle, reading, escape, error) and the drain sequencer.
// Depends on efr_pkg and the assertion macro header.
`default_nettype none
`include "escaped_frame_receiver_unit_defines.svh"

module efr_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire efr_pkg::sts_t sts,
    output efr_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_READING = 3'd1;
    localparam logic [2:0] ST_ESCAPE  = 3'd2;
    localparam logic [2:0] ST_ERROR   = 3'd3;
    localparam logic [2:0] ST_RD      = 3'd4;
    localparam logic [2:0] ST_OUT     = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       s_fire;
    logic       m_fire;

    assign s_tready = (state_reg == ST_IDLE) || (state_reg == ST_READING) ||
                      (state_reg == ST_ESCAPE) || (state_reg == ST_ERROR);
    assign m_tvalid = (state_reg == ST_OUT);
    assign s_fire   = s_tvalid & s_tready;
    assign m_fire   = m_tvalid & m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && sts.is_start) begin
                    state_next     = ST_READING;
                    cmd.clear_fill = 1'b1;
                end
            end
            ST_READING, ST_ESCAPE: begin
                if (s_fire) begin
                    priority if (state_reg == ST_READING && sts.is_stop) begin
                        cmd.clear_idx = 1'b1;
                        state_next    = sts.len_zero ? ST_OUT : ST_RD;
                    end else if (state_reg == ST_READING && sts.is_escape) begin
                        state_next = ST_ESCAPE;
                    end else if (sts.full) begin
                        state_next = ST_ERROR;
                    end else begin
                        cmd.store  = 1'b1;
                        state_next = ST_READING;
                    end
                end
            end
            ST_ERROR: begin
                // discard one beat whatever it holds
                if (s_fire) begin
                    cmd.clear_fill = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_fire) begin
                    if (sts.len_zero || sts.at_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.inc_idx = 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `EFR_ASSERT_NOW(a_no_rx_while_tx, aclk, aresetn, m_tvalid, !s_tready)
    `EFR_ASSERT_NEXT(a_error_to_idle, aclk, aresetn, (state_reg == ST_ERROR) && s_fire, state_reg == ST_IDLE)
    `EFR_ASSERT_NEXT(a_stop_drains, aclk, aresetn, (state_reg == ST_READING) && s_fire && sts.is_stop, (state_reg == ST_RD) || (state_reg == ST_OUT))
    `EFR_ASSERT_NEXT(a_last_to_idle, aclk, aresetn, m_fire && (sts.len_zero || sts.at_last), state_reg == ST_IDLE)

endmodule

`default_nettype wire

// ===== rtl/escaped_frame_receiver_unit.sv =====
// Byte-stuffed frame receiver: one rx beat per cycle while receiving; a closed
// frame of n bytes is drained as n beats (one beat for an empty frame).
// After the stop beat the frame store is read in ST_RD (registered read data) before ST_OUT
// offers the first result beat (an empty frame goes straight to ST_OUT); each further
// byte passes through ST_RD and ST_OUT again. Input is held off while draining.
// Synchronous active-low reset: markers 18/19/125, idle, fill 0.
`default_nettype none

module escaped_frame_receiver_unit #(
    parameter int FRAME_BYTES = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [efr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [efr_pkg::BYTE_W-1:0]         cfg_wdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [efr_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] rx_byte
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [efr_pkg::M_TDATA_W-1:0]      m_tdata,   // [7:0] payload_byte,
                                                               // [13:8] frame_length
    output logic                                    m_tlast
);

    efr_pkg::cmd_t cmd;
    efr_pkg::sts_t sts;

    efr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    efr_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .rx_byte   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking bench for escaped_frame_receiver_unit: a directed script, then random
// frames under several marker settings, scored against an in-bench deframer model.
// Depends on efr_pkg and the unit's RTL only.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import efr_pkg::*;

    localparam int FRAME_BYTES = 32;
    localparam int PHASE_ITEMS = 45;
    localparam int DRAIN_GUARD = 8;
    localparam int STALL_LIMIT = 2000;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {RX_IDLE, RX_READING, RX_ESCAPE, RX_ERROR} rx_mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload;
        logic [LEN_W-1:0]  length;
        logic              last;
    } beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              typed;
        beat_t             want;
    } script_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_START;
    logic [BYTE_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    escaped_frame_receiver_unit #(.FRAME_BYTES(FRAME_BYTES)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // deframer model state
    logic [BYTE_W-1:0] start_mark  = START_RESET;
    logic [BYTE_W-1:0] stop_mark   = STOP_RESET;
    logic [BYTE_W-1:0] escape_mark = ESCAPE_RESET;
    rx_mode_t          rx_mode     = RX_IDLE;
    logic [BYTE_W-1:0] frame_buf [FRAME_BYTES];
    int                fill        = 0;

    beat_t released[$];
    beat_t expected_beats[$];
    beat_t head_beat;

    int errors       = 0;
    int phase_items  = 0;
    int gap_odds     = 0;
    int stall_cycles = 0;
    bit calm         = 1'b0;

    script_row_t script [20] = '{
        '{8'h00,        1'b0, '0},
        '{8'hFF,        1'b0, '0},
        '{STOP_RESET,   1'b0, '0},
        '{ESCAPE_RESET, 1'b0, '0},
        '{START_RESET,  1'b0, '0},
        '{STOP_RESET,   1'b1, '{8'h00, 6'd0, 1'b1}},
        '{START_RESET,  1'b0, '0},
        '{8'hFF,        1'b0, '0},
        '{STOP_RESET,   1'b1, '{8'hFF, 6'd1, 1'b1}},
        '{START_RESET,  1'b0, '0},
        '{8'h00,        1'b0, '0},
        '{START_RESET,  1'b0, '0},
        '{ESCAPE_RESET, 1'b0, '0},
        '{STOP_RESET,   1'b0, '0},
        '{ESCAPE_RESET, 1'b0, '0},
        '{ESCAPE_RESET, 1'b0, '0},
        '{ESCAPE_RESET, 1'b0, '0},
        '{START_RESET,  1'b0, '0},
        '{8'hA5,        1'b0, '0},
        '{STOP_RESET,   1'b0, '0}
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void take_byte(input logic [BYTE_W-1:0] b);
        if (fill >= FRAME_BYTES) begin
            rx_mode = RX_ERROR;
        end else begin
            frame_buf[fill] = b;
            fill++;
            rx_mode = RX_READING;
        end
    endfunction

    // advance the model by one rx byte; results land in released
    function automatic bit deframe(input logic [BYTE_W-1:0] b);
        bit   ignored;
        int   k;
        logic [LEN_W-1:0] len;
        ignored = 1'b0;
        released.delete();
        len = fill[LEN_W-1:0];
        case (rx_mode)
            RX_IDLE: begin
                if (b == start_mark) begin
                    rx_mode = RX_READING;
                    fill = 0;
                end else begin
                    ignored = 1'b1;
                end
            end
            RX_READING: begin
                if (b == stop_mark) begin
                    rx_mode = RX_IDLE;
                    if (fill == 0) begin
                        released.push_back('{8'h00, 6'd0, 1'b1});
                    end else begin
                        for (k = 0; k < fill; k++)
                            released.push_back('{frame_buf[k], len, (k + 1 == fill)});
                    end
                end else if (b == escape_mark) begin
                    rx_mode = RX_ESCAPE;
                end else begin
                    take_byte(b);
                end
            end
            RX_ESCAPE: take_byte(b);
            default: begin
                rx_mode = RX_IDLE;
                fill = 0;
            end
        endcase
        return ignored;
    endfunction

    task automatic send_rx(input logic [BYTE_W-1:0] b, input bit typed, input beat_t want);
        if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        if (!deframe(b))
            phase_items++;
        if (typed) begin
            expected_beats.push_back(want);
        end else begin
            foreach (released[i])
                expected_beats.push_back(released[i]);
        end
    endtask

    // escape marker values, and now and then an ordinary byte too
    task automatic send_payload(input logic [BYTE_W-1:0] b);
        if (b == stop_mark || b == escape_mark || $urandom_range(0, 7) == 0)
            send_rx(escape_mark, 1'b0, '0);
        send_rx(b, 1'b0, '0);
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_GUARD) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_START:  start_mark  = val;
            CFG_STOP:   stop_mark   = val;
            CFG_ESCAPE: escape_mark = val;
            default: ;
        endcase
    endtask

    task automatic random_frame();
        int pick;
        int n;
        pick = $urandom_range(0, 15);
        gap_odds = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
        if (pick < 2) begin
            repeat ($urandom_range(1, 4)) send_rx(BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
        end else if (pick < 4) begin
            // truncated frame, possibly with a start marker as data
            send_rx(start_mark, 1'b0, '0);
            repeat ($urandom_range(0, 5)) send_rx(BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
            if ($urandom_range(0, 1) == 0)
                send_rx(start_mark, 1'b0, '0);
        end else if (pick < 5) begin
            // fill the store, push one more, then the byte that gets discarded
            send_rx(start_mark, 1'b0, '0);
            repeat (FRAME_BYTES) send_payload(BYTE_W'($urandom_range(0, 255)));
            send_payload(BYTE_W'($urandom_range(0, 255)));
            send_rx(($urandom_range(0, 1) == 0) ? start_mark
                                                : BYTE_W'($urandom_range(0, 255)),
                    1'b0, '0);
        end else begin
            if (pick == 5)
                n = FRAME_BYTES;
            else if (pick < 8)
                n = $urandom_range(7, FRAME_BYTES - 1);
            else
                n = $urandom_range(0, 6);
            send_rx(start_mark, 1'b0, '0);
            repeat (n) send_payload(BYTE_W'($urandom_range(0, 255)));
            send_rx(stop_mark, 1'b0, '0);
        end
    endtask

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t ns: result beat with none expected, expected none, got %h/%b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                head_beat = expected_beats.pop_front();
                check_field("payload_byte", int'(head_beat.payload),
                            int'(m_tdata[BYTE_W-1:0]));
                check_field("frame_length", int'(head_beat.length),
                            int'(m_tdata[BYTE_W +: LEN_W]));
                check_field("last_byte", int'(head_beat.last), int'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("%0t ns: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // result side back-pressure
    initial begin
        @(posedge aclk);
        forever begin
            if (calm || $urandom_range(0, 1) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
        end
    end

    initial begin
        int ph;
        bit paused;
        logic [BYTE_W-1:0] st, sp, es;
        paused = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i])
            send_rx(script[i].rx, script[i].typed, script[i].want);

        phase_items = 0;
        while (phase_items < PHASE_ITEMS) random_frame();

        for (ph = 1; ph < 6; ph++) begin
            case (ph)
                1: begin st = 8'h00; sp = 8'hFF; es = 8'h80; end
                2: begin st = 8'hFF; sp = 8'h00; es = 8'h01; end
                3: begin st = 8'h7E; sp = 8'h7E; es = 8'h7D; end
                default: begin
                    do begin
                        st = BYTE_W'($urandom_range(0, 255));
                        sp = BYTE_W'($urandom_range(0, 255));
                        es = BYTE_W'($urandom_range(0, 255));
                    end while (st == sp || st == es || sp == es);
                end
            endcase
            wait_quiet();
            write_reg(CFG_START, st);
            write_reg(CFG_STOP, sp);
            write_reg(CFG_ESCAPE, es);
            if (ph == 2)
                write_reg(CFG_SPARE, BYTE_W'($urandom_range(0, 255)));
            cfg_we <= 1'b0;
            calm = (ph == 5);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                random_frame();
                if (ph == 2 && !paused && phase_items >= PHASE_ITEMS / 2) begin
                    wait_quiet();
                    paused = 1'b1;
                end
            end
        end

        wait_quiet();
        repeat (16) @(posedge aclk);
        if (expected_beats.size() != 0) begin
            $display("%0t ns: %0d result beats never arrived", $time, expected_beats.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
